FILE: sv/crct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crct_pkg
// Shared types, record constants and the CRC-16 byte step for the tare
// record codec.
// ----------------------------------------------------------------------------
package crct_pkg;

    localparam logic [31:0] REC_MAGIC   = 32'h4552_4154;
    localparam logic [15:0] REC_VERSION = 16'h0001;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    localparam logic [3:0] REC_LEN   = 4'd12;
    localparam logic [3:0] LAST_IDX  = 4'd11;
    localparam logic [3:0] CRC_SPAN  = 4'd10;
    localparam logic [3:0] VER_LO    = 4'd4;
    localparam logic [3:0] VER_HI    = 4'd5;
    localparam logic [3:0] TARE_LO   = 4'd6;
    localparam logic [3:0] CRC_LO    = 4'd10;
    localparam logic [3:0] CRC_HI    = 4'd11;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_CRC     = 3'd4
    } t_status;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] tare_value;
        logic [7:0]         data_byte;
        logic               end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         record_byte;
        logic               last_byte;
        t_status            decode_status;
        logic signed [31:0] decoded_tare;
    } t_out_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_word;

    typedef struct packed {
        logic       step;
        logic [7:0] data;
        logic       eob;
    } t_dec_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] tare;
    } t_verdict;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = REC_MAGIC[7:0];
            2'd1:    m = REC_MAGIC[15:8];
            2'd2:    m = REC_MAGIC[23:16];
            2'd3:    m = REC_MAGIC[31:24];
            default: m = REC_MAGIC[7:0];
        endcase
        return m;
    endfunction

endpackage

FILE: sv/crct_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crct_in_if
// Input channel of the tare record codec: valid/ready and one command word.
// ----------------------------------------------------------------------------
interface crct_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] tare_value;
    logic [7:0]         data_byte;
    logic               end_of_buffer;

    modport source (output valid, cmd, tare_value, data_byte, end_of_buffer, input ready);
    modport sink   (input valid, cmd, tare_value, data_byte, end_of_buffer, output ready);
endinterface

FILE: sv/crct_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crct_out_if
// Result channel of the tare record codec: valid/ready and one result word.
// ----------------------------------------------------------------------------
interface crct_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [7:0]         record_byte;
    logic               last_byte;
    logic [2:0]         decode_status;
    logic signed [31:0] decoded_tare;

    modport source (output valid, result_kind, record_byte, last_byte, decode_status,
                    decoded_tare, input ready);
    modport sink   (input valid, result_kind, record_byte, last_byte, decode_status,
                    decoded_tare, output ready);
endinterface

FILE: sv/crct_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crct_encoder
// Walks the twelve record bytes for one tare value, folding bytes 0..9 into
// a running CRC so the checksum bytes are ready at offsets 10 and 11.
// ----------------------------------------------------------------------------
module crct_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic signed [31:0]  i_tare,
    output crct_pkg::t_enc_word o_enc
);

    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  w_data;

    always_comb begin
        case (r_idx)
            4'd0:    w_data = crct_pkg::magic_byte(2'd0);
            4'd1:    w_data = crct_pkg::magic_byte(2'd1);
            4'd2:    w_data = crct_pkg::magic_byte(2'd2);
            4'd3:    w_data = crct_pkg::magic_byte(2'd3);
            4'd4:    w_data = crct_pkg::REC_VERSION[7:0];
            4'd5:    w_data = crct_pkg::REC_VERSION[15:8];
            4'd6:    w_data = i_tare[7:0];
            4'd7:    w_data = i_tare[15:8];
            4'd8:    w_data = i_tare[23:16];
            4'd9:    w_data = i_tare[31:24];
            4'd10:   w_data = r_crc[7:0];
            4'd11:   w_data = r_crc[15:8];
            default: w_data = 8'h00;
        endcase
    end

    assign o_enc.data = w_data;
    assign o_enc.last = (r_idx == crct_pkg::LAST_IDX);

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (i_step) begin
            if (r_idx == crct_pkg::LAST_IDX) begin
                n_idx = 4'd0;
                n_crc = crct_pkg::CRC_INIT;
            end else begin
                n_idx = r_idx + 4'd1;
                if (r_idx < crct_pkg::CRC_SPAN) begin
                    n_crc = crct_pkg::crc_byte(r_crc, w_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
            r_crc <= crct_pkg::CRC_INIT;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= crct_pkg::LAST_IDX)
        else $error("encoder index out of range");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (r_idx == crct_pkg::LAST_IDX) |=> (r_idx == 4'd0) && (r_crc == crct_pkg::CRC_INIT))
        else $error("encoder did not rewind after last byte");

endmodule

FILE: sv/crct_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crct_decoder
// Gathers decode bytes into the record checks and forms the verdict on the
// end marker, then clears for the next buffer.
// ----------------------------------------------------------------------------
module crct_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crct_pkg::t_dec_req i_req,
    output crct_pkg::t_verdict o_verdict
);

    logic [3:0]  r_count;
    logic [15:0] r_crc;
    logic        r_magic_bad;
    logic        r_ver_bad;
    logic [31:0] r_tare;
    logic [15:0] r_stored;

    logic [3:0]  n_count;
    logic [15:0] n_crc;
    logic        n_magic_bad;
    logic        n_ver_bad;
    logic [31:0] n_tare;
    logic [15:0] n_stored;

    logic [3:0]  w_off;

    assign w_off = r_count - crct_pkg::TARE_LO;

    always_comb begin
        n_count     = r_count;
        n_crc       = r_crc;
        n_magic_bad = r_magic_bad;
        n_ver_bad   = r_ver_bad;
        n_tare      = r_tare;
        n_stored    = r_stored;
        if (r_count < crct_pkg::REC_LEN) begin
            if (r_count inside {[4'd0:4'd3]}) begin
                if (i_req.data != crct_pkg::magic_byte(r_count[1:0])) begin
                    n_magic_bad = 1'b1;
                end
            end else if (r_count == crct_pkg::VER_LO) begin
                if (i_req.data != crct_pkg::REC_VERSION[7:0]) begin
                    n_ver_bad = 1'b1;
                end
            end else if (r_count == crct_pkg::VER_HI) begin
                if (i_req.data != crct_pkg::REC_VERSION[15:8]) begin
                    n_ver_bad = 1'b1;
                end
            end else if (r_count inside {[4'd6:4'd9]}) begin
                n_tare[{w_off[1:0], 3'b000} +: 8] = i_req.data;
            end else if (r_count == crct_pkg::CRC_LO) begin
                n_stored[7:0] = i_req.data;
            end else if (r_count == crct_pkg::CRC_HI) begin
                n_stored[15:8] = i_req.data;
            end
            if (r_count < crct_pkg::CRC_SPAN) begin
                n_crc = crct_pkg::crc_byte(r_crc, i_req.data);
            end
            n_count = r_count + 4'd1;
        end
    end

    always_comb begin
        o_verdict.tare = 32'sd0;
        if (n_count < crct_pkg::REC_LEN) begin
            o_verdict.status = crct_pkg::ST_SHORT;
        end else if (n_magic_bad) begin
            o_verdict.status = crct_pkg::ST_MAGIC;
        end else if (n_ver_bad) begin
            o_verdict.status = crct_pkg::ST_VERSION;
        end else if (n_stored != n_crc) begin
            o_verdict.status = crct_pkg::ST_CRC;
        end else begin
            o_verdict.status = crct_pkg::ST_OK;
            o_verdict.tare   = n_tare;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_req.step && i_req.eob)) begin
            r_count     <= 4'd0;
            r_crc       <= crct_pkg::CRC_INIT;
            r_magic_bad <= 1'b0;
            r_ver_bad   <= 1'b0;
            r_tare      <= 32'h0;
            r_stored    <= 16'h0;
        end else if (i_req.step) begin
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_magic_bad <= n_magic_bad;
            r_ver_bad   <= n_ver_bad;
            r_tare      <= n_tare;
            r_stored    <= n_stored;
        end
    end

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= crct_pkg::REC_LEN)
        else $error("decode byte count past record length");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.step && i_req.eob |=> (r_count == 4'd0) && (r_crc == crct_pkg::CRC_INIT))
        else $error("decode state not cleared after verdict");

endmodule

FILE: sv/crc_checked_tare_record_codec.sv
`timescale 1ns / 1ps
// Throughput: one decode word per cycle (an end-of-buffer word waits for the output);
// an encode word yields twelve bytes, one per cycle while the receiver is ready, set by
// the single output register, and the next word is taken as the twelfth byte loads.
// Reset: synchronous, active low; clears both valid flags, the encoder byte index and
// the decode state (count zero, CRC 0xFFFF, flags and gathered fields zero).
// ----------------------------------------------------------------------------
// crc_checked_tare_record_codec
// Encodes a tare value into a 12-byte CRC-16 checked record and checks
// streamed record bytes, one input register and one result register.
// ----------------------------------------------------------------------------
module crc_checked_tare_record_codec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crct_in_if.sink          i_in,
    crct_out_if.source       o_out
);

    logic                 r_in_valid;
    crct_pkg::t_in_word   r_in;
    logic                 r_out_valid;
    crct_pkg::t_out_word  r_out;
    crct_pkg::t_out_word  n_out;

    crct_pkg::t_enc_word  w_enc;
    crct_pkg::t_dec_req   w_dec_req;
    crct_pkg::t_verdict   w_verdict;

    logic w_is_dec;
    logic w_word_valid;
    logic w_out_load;
    logic w_retire;

    assign w_is_dec     = (r_in.cmd == crct_pkg::CMD_DECODE);
    assign w_word_valid = r_in_valid && (!w_is_dec || r_in.end_of_buffer);
    assign w_out_load   = w_word_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        if (!r_in_valid) begin
            w_retire = 1'b0;
        end else if (w_is_dec) begin
            w_retire = r_in.end_of_buffer ? w_out_load : 1'b1;
        end else begin
            w_retire = w_out_load && w_enc.last;
        end
    end

    assign i_in.ready = !r_in_valid || w_retire;

    assign w_dec_req.step = r_in_valid && w_is_dec && w_retire;
    assign w_dec_req.data = r_in.data_byte;
    assign w_dec_req.eob  = r_in.end_of_buffer;

    crct_encoder u_encoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && !w_is_dec && w_out_load),
        .i_tare  (r_in.tare_value),
        .o_enc   (w_enc)
    );

    crct_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_dec_req),
        .o_verdict (w_verdict)
    );

    always_comb begin
        if (w_is_dec) begin
            n_out.result_kind   = crct_pkg::KIND_VERDICT;
            n_out.record_byte   = 8'h00;
            n_out.last_byte     = 1'b0;
            n_out.decode_status = w_verdict.status;
            n_out.decoded_tare  = w_verdict.tare;
        end else begin
            n_out.result_kind   = crct_pkg::KIND_BYTE;
            n_out.record_byte   = w_enc.data;
            n_out.last_byte     = w_enc.last;
            n_out.decode_status = crct_pkg::ST_OK;
            n_out.decoded_tare  = 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.cmd           <= i_in.cmd;
            r_in.tare_value    <= i_in.tare_value;
            r_in.data_byte     <= i_in.data_byte;
            r_in.end_of_buffer <= i_in.end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out.result_kind;
    assign o_out.record_byte   = r_out.record_byte;
    assign o_out.last_byte     = r_out.last_byte;
    assign o_out.decode_status = r_out.decode_status;
    assign o_out.decoded_tare  = r_out.decoded_tare;

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_retire |=> r_in_valid && $stable(r_in))
        else $error("input stage lost a word before retiring it");

    a_encode_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && !w_is_dec && !w_enc.last |=> r_in_valid && (r_in.cmd == crct_pkg::CMD_ENCODE))
        else $error("encode word retired before its last byte");

endmodule

FILE: tb/sv/crc_checked_tare_record_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_tare_record_codec_test
// Drives encode and decode words into the tare record codec under random
// sender bursts and receiver stalls. A local predictor of the record format
// (magic, version, tare, CRC-16) gives every record byte and verdict,
// and each returned word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module crc_checked_tare_record_codec_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_WORDS  = 200;
    localparam int PRESSURE_HOLD = 90;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} t_rx_mode;
    typedef enum {
        FLAW_NONE, FLAW_SHORT, FLAW_MAGIC, FLAW_VERSION, FLAW_CRC, FLAW_EXTRA, FLAW_NOISE
    } t_flaw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crct_in_if  in_ch ();
    crct_out_if out_ch ();

    crc_checked_tare_record_codec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decode state of the predictor
    int          dec_count;
    logic [15:0] dec_crc;
    logic        dec_magic_bad;
    logic        dec_version_bad;
    logic [31:0] dec_tare;
    logic [15:0] dec_stored_crc;

    crct_pkg::t_out_word results_due[$];
    crct_pkg::t_out_word oldest_due;

    int       mismatches  = 0;
    int       cycles      = 0;
    int       words_sent  = 0;
    int       burst_left  = 0;
    int       tx_burst_max = 8;
    int       tx_gap_max   = 4;
    t_rx_mode rx_mode      = RX_OPEN;
    logic [7:0] rx_mask    = 8'b1011_0110;
    int       hold_asks    = 0;
    int       hold_taken   = 0;
    int       hold_left    = 0;

    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ crct_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [95:0] build_record_image(input logic [31:0] tare);
        logic [95:0] img;
        logic [15:0] acc;
        img[31:0]  = crct_pkg::REC_MAGIC;
        img[47:32] = crct_pkg::REC_VERSION;
        img[79:48] = tare;
        acc = crct_pkg::CRC_INIT;
        for (int i = 0; i < 10; i++) begin
            acc = crc16_next(acc, img[8*i +: 8]);
        end
        img[95:80] = acc;
        return img;
    endfunction

    function automatic void clear_decode_state();
        dec_count       = 0;
        dec_crc         = crct_pkg::CRC_INIT;
        dec_magic_bad   = 1'b0;
        dec_version_bad = 1'b0;
        dec_tare        = '0;
        dec_stored_crc  = '0;
    endfunction

    function automatic void compute_codec_results(input crct_pkg::t_in_word w);
        crct_pkg::t_out_word r;
        logic [95:0]         img;
        int                  idx;
        if (w.cmd == crct_pkg::CMD_ENCODE) begin
            img = build_record_image(w.tare_value);
            for (int i = 0; i < 12; i++) begin
                r = '0;
                r.result_kind   = crct_pkg::KIND_BYTE;
                r.record_byte   = img[8*i +: 8];
                r.last_byte     = (i == 11);
                r.decode_status = crct_pkg::ST_OK;
                results_due.push_back(r);
            end
            return;
        end
        idx = dec_count;
        if (idx < 12) begin
            if (idx < 4) begin
                if (w.data_byte != crct_pkg::REC_MAGIC[8*idx +: 8]) dec_magic_bad = 1'b1;
            end else if (idx < 6) begin
                if (w.data_byte != crct_pkg::REC_VERSION[8*(idx-4) +: 8]) dec_version_bad = 1'b1;
            end else if (idx < 10) begin
                dec_tare[8*(idx-6) +: 8] = w.data_byte;
            end else begin
                dec_stored_crc[8*(idx-10) +: 8] = w.data_byte;
            end
            if (idx < 10) dec_crc = crc16_next(dec_crc, w.data_byte);
            dec_count = idx + 1;
        end
        if (!w.end_of_buffer) return;
        r = '0;
        r.result_kind = crct_pkg::KIND_VERDICT;
        if (dec_count < 12) begin
            r.decode_status = crct_pkg::ST_SHORT;
        end else if (dec_magic_bad) begin
            r.decode_status = crct_pkg::ST_MAGIC;
        end else if (dec_version_bad) begin
            r.decode_status = crct_pkg::ST_VERSION;
        end else if (dec_stored_crc != dec_crc) begin
            r.decode_status = crct_pkg::ST_CRC;
        end else begin
            r.decode_status = crct_pkg::ST_OK;
            r.decoded_tare  = dec_tare;
        end
        results_due.push_back(r);
        clear_decode_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    // Send one word; valid stays high within a burst and drops at its end.
    task automatic send_word(input logic cmd, input logic [31:0] tare,
                             input logic [7:0] data, input logic eob);
        crct_pkg::t_in_word w;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, tx_gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, tx_burst_max);
        end
        w.cmd           = cmd;
        w.tare_value    = tare;
        w.data_byte     = data;
        w.end_of_buffer = eob;
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= cmd;
        in_ch.tare_value    <= tare;
        in_ch.data_byte     <= data;
        in_ch.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        compute_codec_results(w);
        words_sent++;
        burst_left--;
        if (burst_left == 0) in_ch.valid <= 1'b0;
    endtask

    task automatic end_burst();
        if (burst_left != 0) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic send_encode(input logic [31:0] tare);
        send_word(crct_pkg::CMD_ENCODE, tare, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_decode(input logic [7:0] data, input logic eob);
        send_word(crct_pkg::CMD_DECODE, $urandom, data, eob);
    endtask

    task automatic wait_drain();
        end_burst();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stream one buffer built from a valid record, damaged as asked, or from random bytes for noise.
    task automatic send_record(input t_flaw flaw);
        logic [95:0] img;
        int          len;
        int          extra;
        int          pos;
        int          encode_at;
        img   = build_record_image($urandom);
        len   = 12;
        extra = 0;
        case (flaw)
            FLAW_SHORT: begin
                len = $urandom_range(1, 11);
            end
            FLAW_MAGIC: begin
                pos = $urandom_range(0, 3);
                img[8*pos +: 8] ^= 8'(1 << $urandom_range(0, 7));
                if ($urandom_range(0, 1)) img[39:32] ^= 8'($urandom_range(1, 255));
            end
            FLAW_VERSION: begin
                pos = $urandom_range(4, 5);
                img[8*pos +: 8] ^= 8'(1 << $urandom_range(0, 7));
                if ($urandom_range(0, 1)) img[95:88] ^= 8'($urandom_range(1, 255));
            end
            FLAW_CRC: begin
                pos = $urandom_range(6, 11);
                img[8*pos +: 8] ^= 8'(1 << $urandom_range(0, 7));
            end
            FLAW_EXTRA: begin
                extra = $urandom_range(1, 5);
            end
            FLAW_NOISE: begin
                img   = {$urandom, $urandom, $urandom};
                len   = $urandom_range(1, 12);
                extra = (len == 12) ? $urandom_range(0, 4) : 0;
            end
            default: begin
            end
        endcase
        encode_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len + extra - 1) : -1;
        for (int i = 0; i < len + extra; i++) begin
            if (i == encode_at) send_encode($urandom);
            send_decode((i < 12) ? img[8*i +: 8] : 8'($urandom), i == len + extra - 1);
        end
    endtask

    task automatic test_encode_extremes();
        send_encode(32'h7FFF_FFFF);
        send_encode(32'h8000_0000);
        send_encode(32'hFFFF_FFFF);
        send_word(crct_pkg::CMD_ENCODE, 32'h0000_0000, 8'hFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_decode_directed();
        logic [95:0] img;
        img = build_record_image(32'h8000_0000);
        for (int i = 0; i < 12; i++) begin
            if (i == 6) send_word(crct_pkg::CMD_ENCODE, 32'h0000_0001, 8'h00, 1'b1);
            send_decode(img[8*i +: 8], i == 11);
        end
        send_decode(8'h54, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int    target;
        t_flaw flaw;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            case ($urandom_range(0, 3))
                0: begin
                    tx_burst_max = 1000;
                    tx_gap_max   = 1;
                    rx_mode      = RX_OPEN;
                end
                1: begin
                    tx_burst_max = 3;
                    tx_gap_max   = 6;
                    rx_mode      = RX_RANDOM;
                end
                2: begin
                    tx_burst_max = 16;
                    tx_gap_max   = 3;
                    rx_mode      = RX_PATTERN;
                end
                default: begin
                    tx_burst_max = 6;
                    tx_gap_max   = 2;
                    rx_mode      = RX_RANDOM;
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                send_encode($urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: flaw = FLAW_NONE;
                    3:       flaw = FLAW_SHORT;
                    4:       flaw = FLAW_MAGIC;
                    5:       flaw = FLAW_VERSION;
                    6:       flaw = FLAW_CRC;
                    7:       flaw = FLAW_EXTRA;
                    default: flaw = FLAW_NOISE;
                endcase
                send_record(flaw);
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_burst_max = 1000;
        tx_gap_max   = 1;
        rx_mode      = RX_OPEN;
        hold_asks++;
        send_encode($urandom);
        send_record(FLAW_NONE);
        send_encode($urandom);
        send_record(FLAW_EXTRA);
        wait_drain();
    endtask

    // receiver: long hold on request, otherwise its own stall pattern
    always @(posedge i_clk) begin
        if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left  = PRESSURE_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 9) < 7);
                RX_PATTERN: out_ch.ready <= rx_mask[0];
                default:    out_ch.ready <= 1'b1;
            endcase
        end
        rx_mask <= {rx_mask[0], rx_mask[7:1]};
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected word", 32'(out_ch.record_byte), 32'h0);
            end else begin
                oldest_due = results_due.pop_front();
                if (out_ch.result_kind !== oldest_due.result_kind)
                    report_mismatch("result_kind", 32'(out_ch.result_kind),
                                    32'(oldest_due.result_kind));
                if (out_ch.record_byte !== oldest_due.record_byte)
                    report_mismatch("record_byte", 32'(out_ch.record_byte),
                                    32'(oldest_due.record_byte));
                if (out_ch.last_byte !== oldest_due.last_byte)
                    report_mismatch("last_byte", 32'(out_ch.last_byte),
                                    32'(oldest_due.last_byte));
                if (out_ch.decode_status !== oldest_due.decode_status)
                    report_mismatch("decode_status", 32'(out_ch.decode_status),
                                    32'(oldest_due.decode_status));
                if (out_ch.decoded_tare !== oldest_due.decoded_tare)
                    report_mismatch("decoded_tare", out_ch.decoded_tare,
                                    oldest_due.decoded_tare);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.cmd           = crct_pkg::CMD_ENCODE;
        in_ch.tare_value    = '0;
        in_ch.data_byte     = '0;
        in_ch.end_of_buffer = 1'b0;
        clear_decode_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_encode_extremes();
        test_decode_directed();
        test_backpressure();
        test_random_traffic();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/crct_pkg.sv
sv/crct_in_if.sv
sv/crct_out_if.sv
sv/crct_encoder.sv
sv/crct_decoder.sv
sv/crc_checked_tare_record_codec.sv
tb/sv/crc_checked_tare_record_codec_test.sv
